[sv/aclcs_pkg.sv]
// Shared constants and helpers for the ASCII command link with checksum and sequence id.
// Holds command, status, reply-match and register index codes and the hex digit helpers.
// No dependencies.
`timescale 1ns / 1ps

package aclcs_pkg;

    // Receive buffer length and token limit of the reply parser
    localparam int BUFFER_LENGTH = 32;
    localparam int MAX_TOKENS    = 10;

    localparam logic [5:0] RX_LIMIT   = 6'(BUFFER_LENGTH - 1);
    localparam logic [3:0] TOKEN_MAX  = 4'(MAX_TOKENS);

    // Input command codes
    localparam logic [1:0] CMD_TX_BYTE = 2'd0;
    localparam logic [1:0] CMD_TX_END  = 2'd1;
    localparam logic [1:0] CMD_RX_BYTE = 2'd2;
    localparam logic [1:0] CMD_TICK    = 2'd3;

    // Result kind codes
    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Transaction status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_REFUSED  = 3'd1;
    localparam logic [2:0] ST_INVALID  = 3'd2;
    localparam logic [2:0] ST_TIMEOUT  = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;

    // First-token match progress
    localparam logic [2:0] MATCH_NONE  = 3'd0;
    localparam logic [2:0] MATCH_O     = 3'd1;
    localparam logic [2:0] MATCH_N     = 3'd2;
    localparam logic [2:0] MATCH_OK    = 3'd3;
    localparam logic [2:0] MATCH_NK    = 3'd4;
    localparam logic [2:0] MATCH_OTHER = 3'd5;
    localparam logic [2:0] MATCH_OK_SP = 3'd6;
    localparam logic [2:0] MATCH_NK_SP = 3'd7;

    // Sequence id capture phases
    localparam logic [1:0] SEQ_NONE = 2'd0;
    localparam logic [1:0] SEQ_DIG1 = 2'd1;
    localparam logic [1:0] SEQ_DIG2 = 2'd2;
    localparam logic [1:0] SEQ_DONE = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_TIMEOUT  = 3'd0;
    localparam logic [2:0] CFG_SEQ_EN   = 3'd1;
    localparam logic [2:0] CFG_SEQ_SEED = 3'd2;
    localparam logic [2:0] CFG_START    = 3'd3;
    localparam logic [2:0] CFG_END      = 3'd4;
    localparam logic [2:0] CFG_SEQ_CHAR = 3'd5;
    localparam logic [2:0] CFG_INVALID  = 3'd6;

    // Fixed characters
    localparam logic [7:0] CHAR_CARET = 8'h5E;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_O     = 8'h4F;
    localparam logic [7:0] CHAR_N     = 8'h4E;
    localparam logic [7:0] CHAR_K     = 8'h4B;

    // One output beat
    typedef struct packed {
        logic       kind;
        logic [7:0] line_byte;
        logic [2:0] status;
    } t_beat;

    // True for '0'-'9' and 'A'-'F'
    function automatic logic hex_ok(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    // Nibble value of a valid hex digit
    function automatic logic [3:0] hex_nib(input logic [7:0] c);
        return (c <= 8'h39) ? c[3:0] : 4'(c[3:0] + 4'd9);
    endfunction

    // Uppercase hex digit for a nibble
    function automatic logic [7:0] hex_char(input logic [3:0] d);
        return (d < 4'd10) ? (8'h30 + {4'd0, d}) : (8'h37 + {4'd0, d});
    endfunction

endpackage

[sv/ascii_command_link_checksum_seq_core.sv]
// ASCII command link core: transmit framing with checksum and sequence id, reply parser.
// Depends on aclcs_pkg for codes, the beat type and the hex helpers.
`timescale 1ns / 1ps

// The block takes one input beat per cycle while its burst is empty or its final beat
// is leaving, doing all its work in that cycle and loading the results into a burst
// register of up to eight beats that drains one beat per cycle while the master is
// ready. End of command holds off input until its four beats (eight with the id) drain.
// A new beat is accepted in the same cycle as the final beat of the previous burst leaves.
// Input tuser carries the command (0 command byte, 1 end of command, 2 received byte,
// 3 tick); output tuser is 1 for a status beat, whose status code sits in tdata[10:8].
// The user must write configuration registers only while the block is idle (not enforced).
module ascii_command_link_checksum_seq_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Slave side
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] command
    // Master side
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [7:0] line_byte, [10:8] status, [15:11] zero
    output logic        o_m_axis_tuser,   // [0] kind
    output logic        o_m_axis_tlast,
    // Configuration write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata
);

    // Configuration registers
    logic [15:0] r_timeout_ticks;
    logic        r_seq_enable;
    logic [7:0]  r_seq_seed, r_start_char, r_end_char, r_seq_char, r_invalid_seq;

    // Link state
    logic [7:0]  r_seq_counter, n_seq_counter;
    logic [7:0]  r_tx_check, n_tx_check;
    logic        r_armed, n_armed;
    logic [5:0]  r_rx_count, n_rx_count;
    logic [7:0]  r_rx_check, n_rx_check;
    logic        r_past_caret, n_past_caret;
    logic [7:0]  r_hex_capture, n_hex_capture;
    logic [1:0]  r_hex_digits, n_hex_digits;
    logic        r_hex_bad, n_hex_bad;
    logic [3:0]  r_token_scan, n_token_scan;
    logic [2:0]  r_reply_match, n_reply_match;
    logic [1:0]  r_seq_phase, n_seq_phase;
    logic [7:0]  r_seq_capture, n_seq_capture;
    logic        r_gap, n_gap;
    logic [15:0] r_tick_count, n_tick_count;

    // Result burst
    aclcs_pkg::t_beat r_burst [8];
    aclcs_pkg::t_beat n_burst [8];
    logic [3:0]  r_count, n_count;

    // Working signals
    logic        accept, take, rx_clear;
    logic [7:0]  c;
    logic [1:0]  cmd;
    logic        c_ok;
    logic [3:0]  c_nib;
    logic [7:0]  seq_inc, seq_next, tx_seq, rx_sum;
    logic [15:0] tick_next;

    assign c    = i_s_axis_tdata;
    assign cmd  = i_s_axis_tuser;
    assign c_ok  = aclcs_pkg::hex_ok(c);
    assign c_nib = aclcs_pkg::hex_nib(c);

    // Handshakes: take a new beat once the burst is empty or its final beat leaves now
    assign take            = (r_count != 4'd0) && i_m_axis_tready;
    assign o_s_axis_tready = (r_count == 4'd0) || ((r_count == 4'd1) && i_m_axis_tready);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    assign o_m_axis_tvalid = (r_count != 4'd0);
    assign o_m_axis_tdata  = {5'd0, r_burst[0].status, r_burst[0].line_byte};
    assign o_m_axis_tuser  = r_burst[0].kind;
    assign o_m_axis_tlast  = (r_count == 4'd1);

    // Next sequence id and checksum with the id bytes folded in
    assign seq_inc  = r_seq_counter + 8'd1;
    assign seq_next = (seq_inc == r_invalid_seq) ? (seq_inc + 8'd1) : seq_inc;
    assign tx_seq   = r_tx_check ^ aclcs_pkg::CHAR_SPACE ^ r_seq_char
                    ^ aclcs_pkg::hex_char(seq_next[7:4]) ^ aclcs_pkg::hex_char(seq_next[3:0]);
    assign rx_sum   = r_hex_bad ? 8'd0 : r_hex_capture;
    assign tick_next = (r_tick_count != 16'hFFFF) ? (r_tick_count + 16'd1) : r_tick_count;

    // Per-beat work: link state update and result burst
    always_comb begin
        n_seq_counter = r_seq_counter;
        n_tx_check    = r_tx_check;
        n_armed       = r_armed;
        n_rx_count    = r_rx_count;
        n_rx_check    = r_rx_check;
        n_past_caret  = r_past_caret;
        n_hex_capture = r_hex_capture;
        n_hex_digits  = r_hex_digits;
        n_hex_bad     = r_hex_bad;
        n_token_scan  = r_token_scan;
        n_reply_match = r_reply_match;
        n_seq_phase   = r_seq_phase;
        n_seq_capture = r_seq_capture;
        n_gap         = r_gap;
        n_tick_count  = r_tick_count;
        rx_clear      = 1'b0;

        // Drain: shift the burst down by one beat when the head beat leaves
        for (int i = 0; i < 7; i++) begin
            n_burst[i] = take ? r_burst[i + 1] : r_burst[i];
        end
        n_burst[7] = r_burst[7];
        n_count    = take ? (r_count - 4'd1) : r_count;

        if (accept) begin
            n_count = 4'd0;
            case (cmd)
                aclcs_pkg::CMD_TX_BYTE: begin
                    n_tx_check = r_tx_check ^ c;
                    n_burst[0] = '{aclcs_pkg::KIND_BYTE, c, aclcs_pkg::ST_OK};
                    n_count    = 4'd1;
                end
                aclcs_pkg::CMD_TX_END: begin
                    if (r_seq_enable) begin
                        n_seq_counter = seq_next;
                        n_burst[0] = '{aclcs_pkg::KIND_BYTE, aclcs_pkg::CHAR_SPACE,
                                       aclcs_pkg::ST_OK};
                        n_burst[1] = '{aclcs_pkg::KIND_BYTE, r_seq_char, aclcs_pkg::ST_OK};
                        n_burst[2] = '{aclcs_pkg::KIND_BYTE,
                                       aclcs_pkg::hex_char(seq_next[7:4]), aclcs_pkg::ST_OK};
                        n_burst[3] = '{aclcs_pkg::KIND_BYTE,
                                       aclcs_pkg::hex_char(seq_next[3:0]), aclcs_pkg::ST_OK};
                        n_burst[4] = '{aclcs_pkg::KIND_BYTE, aclcs_pkg::CHAR_CARET,
                                       aclcs_pkg::ST_OK};
                        n_burst[5] = '{aclcs_pkg::KIND_BYTE,
                                       aclcs_pkg::hex_char(tx_seq[7:4]), aclcs_pkg::ST_OK};
                        n_burst[6] = '{aclcs_pkg::KIND_BYTE,
                                       aclcs_pkg::hex_char(tx_seq[3:0]), aclcs_pkg::ST_OK};
                        n_burst[7] = '{aclcs_pkg::KIND_BYTE, r_end_char, aclcs_pkg::ST_OK};
                        n_count    = 4'd8;
                    end else begin
                        n_burst[0] = '{aclcs_pkg::KIND_BYTE, aclcs_pkg::CHAR_CARET,
                                       aclcs_pkg::ST_OK};
                        n_burst[1] = '{aclcs_pkg::KIND_BYTE,
                                       aclcs_pkg::hex_char(r_tx_check[7:4]), aclcs_pkg::ST_OK};
                        n_burst[2] = '{aclcs_pkg::KIND_BYTE,
                                       aclcs_pkg::hex_char(r_tx_check[3:0]), aclcs_pkg::ST_OK};
                        n_burst[3] = '{aclcs_pkg::KIND_BYTE, r_end_char, aclcs_pkg::ST_OK};
                        n_count    = 4'd4;
                    end
                    n_tx_check   = 8'd0;
                    n_armed      = 1'b1;
                    n_tick_count = 16'd0;
                    rx_clear     = 1'b1;
                end
                aclcs_pkg::CMD_RX_BYTE: begin
                    if (!r_armed) begin
                        // drop: receiver idle
                    end else if ((r_rx_count == 6'd0) && (c != r_start_char)) begin
                        // drop: waiting for start of frame
                    end else if ((r_rx_count != 6'd0) && (c == r_end_char)) begin
                        // Frame end: checksum, empty token part, sequence id, then status
                        rx_clear = 1'b1;
                        if (!(r_past_caret && (rx_sum != r_rx_check))
                                && (r_token_scan != 4'd0)
                                && !((r_seq_phase != aclcs_pkg::SEQ_NONE)
                                     && (r_seq_capture != r_seq_counter))) begin
                            n_armed = 1'b0;
                            n_count = 4'd1;
                            if ((r_reply_match == aclcs_pkg::MATCH_OK)
                                    || (r_reply_match == aclcs_pkg::MATCH_OK_SP)) begin
                                n_burst[0] = '{aclcs_pkg::KIND_STATUS, 8'd0, aclcs_pkg::ST_OK};
                            end else if ((r_reply_match == aclcs_pkg::MATCH_NK)
                                    || (r_reply_match == aclcs_pkg::MATCH_NK_SP)) begin
                                n_burst[0] = '{aclcs_pkg::KIND_STATUS, 8'd0,
                                               aclcs_pkg::ST_REFUSED};
                            end else begin
                                n_burst[0] = '{aclcs_pkg::KIND_STATUS, 8'd0,
                                               aclcs_pkg::ST_INVALID};
                            end
                        end
                    end else begin
                        n_rx_count = r_rx_count + 6'd1;
                        if (!r_past_caret) begin
                            if (c == aclcs_pkg::CHAR_CARET) begin
                                n_past_caret = 1'b1;
                            end else begin
                                n_rx_check = r_rx_check ^ c;
                                // Tokenize the part before the caret
                                if (r_seq_phase != aclcs_pkg::SEQ_NONE) begin
                                    if (r_seq_phase != aclcs_pkg::SEQ_DONE) begin
                                        if (!c_ok) begin
                                            n_seq_capture = 8'd0;
                                            n_seq_phase   = aclcs_pkg::SEQ_DONE;
                                        end else begin
                                            n_seq_capture = {r_seq_capture[3:0], c_nib};
                                            n_seq_phase   = r_seq_phase + 2'd1;
                                        end
                                    end
                                end else if (r_token_scan >= aclcs_pkg::TOKEN_MAX) begin
                                    // hold: token limit reached
                                end else if (r_token_scan == 4'd0) begin
                                    n_token_scan = 4'd1;
                                    n_gap        = 1'b0;
                                end else if (r_gap) begin
                                    if (c == r_seq_char) begin
                                        n_seq_phase = aclcs_pkg::SEQ_DIG1;
                                    end else begin
                                        n_token_scan = r_token_scan + 4'd1;
                                        n_gap        = 1'b0;
                                    end
                                end else if (c == aclcs_pkg::CHAR_SPACE) begin
                                    n_gap = 1'b1;
                                    if (r_token_scan == 4'd1) begin
                                        if (r_reply_match == aclcs_pkg::MATCH_OK) begin
                                            n_reply_match = aclcs_pkg::MATCH_OK_SP;
                                        end else if (r_reply_match == aclcs_pkg::MATCH_NK) begin
                                            n_reply_match = aclcs_pkg::MATCH_NK_SP;
                                        end else if (r_reply_match < aclcs_pkg::MATCH_OK) begin
                                            n_reply_match = aclcs_pkg::MATCH_OTHER;
                                        end
                                    end
                                end else if (r_token_scan == 4'd1) begin
                                    case (r_reply_match)
                                        aclcs_pkg::MATCH_NONE: begin
                                            if (c == aclcs_pkg::CHAR_O) begin
                                                n_reply_match = aclcs_pkg::MATCH_O;
                                            end else if (c == aclcs_pkg::CHAR_N) begin
                                                n_reply_match = aclcs_pkg::MATCH_N;
                                            end else begin
                                                n_reply_match = aclcs_pkg::MATCH_OTHER;
                                            end
                                        end
                                        aclcs_pkg::MATCH_O: begin
                                            n_reply_match = (c == aclcs_pkg::CHAR_K)
                                                ? aclcs_pkg::MATCH_OK : aclcs_pkg::MATCH_OTHER;
                                        end
                                        aclcs_pkg::MATCH_N: begin
                                            n_reply_match = (c == aclcs_pkg::CHAR_K)
                                                ? aclcs_pkg::MATCH_NK : aclcs_pkg::MATCH_OTHER;
                                        end
                                        aclcs_pkg::MATCH_OK, aclcs_pkg::MATCH_NK: begin
                                            n_reply_match = aclcs_pkg::MATCH_OTHER;
                                        end
                                        default: begin
                                        end
                                    endcase
                                end
                            end
                        end else if (r_hex_digits < 2'd2) begin
                            // Collect the checksum digits; a bad digit zeroes the value
                            n_hex_digits = r_hex_digits + 2'd1;
                            if (!c_ok) begin
                                n_hex_bad = 1'b1;
                            end else begin
                                n_hex_capture = {r_hex_capture[3:0], c_nib};
                            end
                        end
                        // Overflow once the buffer is full
                        if (n_rx_count >= aclcs_pkg::RX_LIMIT) begin
                            rx_clear   = 1'b1;
                            n_armed    = 1'b0;
                            n_burst[0] = '{aclcs_pkg::KIND_STATUS, 8'd0, aclcs_pkg::ST_OVERFLOW};
                            n_count    = 4'd1;
                        end
                    end
                end
                default: begin
                    // Tick: count while armed and time out
                    if (r_armed) begin
                        n_tick_count = tick_next;
                        if (tick_next >= r_timeout_ticks) begin
                            rx_clear   = 1'b1;
                            n_armed    = 1'b0;
                            n_burst[0] = '{aclcs_pkg::KIND_STATUS, 8'd0, aclcs_pkg::ST_TIMEOUT};
                            n_count    = 4'd1;
                        end
                    end
                end
            endcase
        end

        // Restart the receiver
        if (rx_clear) begin
            n_rx_count    = 6'd0;
            n_rx_check    = 8'd0;
            n_past_caret  = 1'b0;
            n_hex_capture = 8'd0;
            n_hex_digits  = 2'd0;
            n_hex_bad     = 1'b0;
            n_token_scan  = 4'd0;
            n_reply_match = aclcs_pkg::MATCH_NONE;
            n_seq_phase   = aclcs_pkg::SEQ_NONE;
            n_seq_capture = 8'd0;
            n_gap         = 1'b0;
        end

        // Writing the enable loads the sequence counter
        if (i_cfg_we && (i_cfg_index == aclcs_pkg::CFG_SEQ_EN)) begin
            n_seq_counter = i_cfg_wdata[0] ? r_seq_seed : r_invalid_seq;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_ticks <= 16'd1000;
            r_seq_enable    <= 1'b0;
            r_seq_seed      <= 8'd1;
            r_start_char    <= 8'd36;
            r_end_char      <= 8'd13;
            r_seq_char      <= 8'd58;
            r_invalid_seq   <= 8'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                aclcs_pkg::CFG_TIMEOUT:  r_timeout_ticks <= i_cfg_wdata;
                aclcs_pkg::CFG_SEQ_EN:   r_seq_enable    <= i_cfg_wdata[0];
                aclcs_pkg::CFG_SEQ_SEED: r_seq_seed      <= i_cfg_wdata[7:0];
                aclcs_pkg::CFG_START:    r_start_char    <= i_cfg_wdata[7:0];
                aclcs_pkg::CFG_END:      r_end_char      <= i_cfg_wdata[7:0];
                aclcs_pkg::CFG_SEQ_CHAR: r_seq_char      <= i_cfg_wdata[7:0];
                aclcs_pkg::CFG_INVALID:  r_invalid_seq   <= i_cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // Link state and burst count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_counter <= 8'd0;
            r_tx_check    <= 8'd0;
            r_armed       <= 1'b0;
            r_rx_count    <= 6'd0;
            r_rx_check    <= 8'd0;
            r_past_caret  <= 1'b0;
            r_hex_capture <= 8'd0;
            r_hex_digits  <= 2'd0;
            r_hex_bad     <= 1'b0;
            r_token_scan  <= 4'd0;
            r_reply_match <= aclcs_pkg::MATCH_NONE;
            r_seq_phase   <= aclcs_pkg::SEQ_NONE;
            r_seq_capture <= 8'd0;
            r_gap         <= 1'b0;
            r_tick_count  <= 16'd0;
            r_count       <= 4'd0;
        end else begin
            r_seq_counter <= n_seq_counter;
            r_tx_check    <= n_tx_check;
            r_armed       <= n_armed;
            r_rx_count    <= n_rx_count;
            r_rx_check    <= n_rx_check;
            r_past_caret  <= n_past_caret;
            r_hex_capture <= n_hex_capture;
            r_hex_digits  <= n_hex_digits;
            r_hex_bad     <= n_hex_bad;
            r_token_scan  <= n_token_scan;
            r_reply_match <= n_reply_match;
            r_seq_phase   <= n_seq_phase;
            r_seq_capture <= n_seq_capture;
            r_gap         <= n_gap;
            r_tick_count  <= n_tick_count;
            r_count       <= n_count;
        end
    end

    // Burst payload
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 8; i++) begin
            r_burst[i] <= n_burst[i];
        end
    end

endmodule

[test/aclcs_link_checker.sv]
// Scoreboard for the ASCII command link core: watches the input, output and register ports.
// Keeps its own model of the framer and the reply parser and compares every output beat.
// Depends on aclcs_pkg for command, status, match and register codes.
`timescale 1ns / 1ps

module aclcs_link_checker
    import aclcs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,    // [7:0] data_byte
    input  logic [1:0]  i_s_tuser,    // [1:0] command
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,    // [7:0] line_byte, [10:8] status, [15:11] zero
    input  logic        i_m_tuser,    // [0] kind
    input  logic        i_m_tlast,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int PRINT_LIMIT = 40;

    typedef struct packed {
        logic       kind;
        logic [7:0] line_byte;
        logic [2:0] status;
        logic       last;
    } link_beat_t;

    link_beat_t expected_beats[$];
    int         fail_total    = 0;
    int         pending_total = 0;

    // Register copies
    logic [15:0] cfg_timeout;
    logic        cfg_seq_en;
    logic [7:0]  cfg_seed, cfg_start, cfg_end, cfg_marker, cfg_invalid;

    // Framer and parser state
    logic [7:0]  seq_id, tx_sum;
    logic        armed;
    logic [5:0]  rx_len;
    logic [7:0]  rx_xor, sum_capture, id_capture;
    logic        caret_seen, sum_bad, after_space;
    logic [1:0]  sum_digits, id_phase;
    logic [3:0]  tokens;
    logic [2:0]  first_tok;
    logic [15:0] ticks;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_total;

    // Value of an uppercase hex digit, -1 for any other byte
    function automatic int digit_value(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
        if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
        return -1;
    endfunction

    function automatic logic [7:0] nibble_char(input logic [3:0] d);
        return (d < 4'd10) ? 8'h30 + 8'(d) : 8'h41 + 8'(d) - 8'd10;
    endfunction

    task automatic push_beat(input logic kind, input logic [7:0] b, input logic [2:0] st,
                             input logic fin);
        link_beat_t beat;
        beat.kind      = kind;
        beat.line_byte = b;
        beat.status    = st;
        beat.last      = fin;
        expected_beats.push_back(beat);
    endtask

    task automatic rx_clear();
        rx_len      = '0;
        rx_xor      = '0;
        caret_seen  = 1'b0;
        sum_capture = '0;
        sum_digits  = '0;
        sum_bad     = 1'b0;
        tokens      = '0;
        first_tok   = MATCH_NONE;
        id_phase    = SEQ_NONE;
        id_capture  = '0;
        after_space = 1'b0;
    endtask

    task automatic link_reset();
        cfg_timeout = 16'd1000;
        cfg_seq_en  = 1'b0;
        cfg_seed    = 8'd1;
        cfg_start   = 8'd36;
        cfg_end     = 8'd13;
        cfg_marker  = 8'd58;
        cfg_invalid = 8'd0;
        seq_id      = cfg_invalid;
        tx_sum      = '0;
        armed       = 1'b0;
        ticks       = '0;
        rx_clear();
        expected_beats.delete();
    endtask

    task automatic apply_reg(input logic [2:0] idx, input logic [15:0] value);
        case (idx)
            CFG_TIMEOUT: cfg_timeout = value;
            CFG_SEQ_EN: begin
                // Enabling loads the seed, disabling parks the counter on the invalid id
                cfg_seq_en = value[0];
                seq_id     = value[0] ? cfg_seed : cfg_invalid;
            end
            CFG_SEQ_SEED: cfg_seed    = value[7:0];
            CFG_START:    cfg_start   = value[7:0];
            CFG_END:      cfg_end     = value[7:0];
            CFG_SEQ_CHAR: cfg_marker  = value[7:0];
            CFG_INVALID:  cfg_invalid = value[7:0];
            default: ;
        endcase
    endtask

    // Byte that goes to the line and into the transmit checksum
    task automatic emit_folded(input logic [7:0] b);
        tx_sum ^= b;
        push_beat(KIND_BYTE, b, ST_OK, 1'b0);
    endtask

    // End of command: optional id, then caret, checksum and end char; arm the receiver
    task automatic close_command();
        if (cfg_seq_en) begin
            seq_id++;
            if (seq_id == cfg_invalid) seq_id++;
            emit_folded(CHAR_SPACE);
            emit_folded(cfg_marker);
            emit_folded(nibble_char(seq_id[7:4]));
            emit_folded(nibble_char(seq_id[3:0]));
        end
        push_beat(KIND_BYTE, CHAR_CARET, ST_OK, 1'b0);
        push_beat(KIND_BYTE, nibble_char(tx_sum[7:4]), ST_OK, 1'b0);
        push_beat(KIND_BYTE, nibble_char(tx_sum[3:0]), ST_OK, 1'b0);
        push_beat(KIND_BYTE, cfg_end, ST_OK, 1'b1);
        tx_sum = '0;
        armed  = 1'b1;
        ticks  = '0;
        rx_clear();
    endtask

    // Split the reply into tokens, track the first token and capture the sequence id
    task automatic take_token_byte(input logic [7:0] c);
        int d;
        if (id_phase != SEQ_NONE) begin
            if (id_phase != SEQ_DONE) begin
                d = digit_value(c);
                if (d < 0) begin
                    id_capture = '0;
                    id_phase   = SEQ_DONE;
                end else begin
                    id_capture = {id_capture[3:0], d[3:0]};
                    id_phase   = id_phase + 2'd1;
                end
            end
            return;
        end
        if (tokens >= TOKEN_MAX) return;
        if (tokens == 4'd0) begin
            tokens      = 4'd1;
            after_space = 1'b0;
            return;
        end
        if (after_space) begin
            if (c == cfg_marker) begin
                id_phase = SEQ_DIG1;
                return;
            end
            tokens++;
            after_space = 1'b0;
            return;
        end
        if (c == CHAR_SPACE) begin
            after_space = 1'b1;
            if (tokens == 4'd1) begin
                if (first_tok == MATCH_OK)      first_tok = MATCH_OK_SP;
                else if (first_tok == MATCH_NK) first_tok = MATCH_NK_SP;
                else if (first_tok < MATCH_OK)  first_tok = MATCH_OTHER;
            end
            return;
        end
        if (tokens != 4'd1) return;
        case (first_tok)
            MATCH_NONE: first_tok = (c == CHAR_O) ? MATCH_O :
                                    (c == CHAR_N) ? MATCH_N : MATCH_OTHER;
            MATCH_O:    first_tok = (c == CHAR_K) ? MATCH_OK : MATCH_OTHER;
            MATCH_N:    first_tok = (c == CHAR_K) ? MATCH_NK : MATCH_OTHER;
            MATCH_OK, MATCH_NK: first_tok = MATCH_OTHER;
            default: ;
        endcase
    endtask

    // End char of a reply: drop on a bad checksum, empty token part or wrong id
    task automatic close_frame();
        logic [7:0] got_sum;
        logic [2:0] st;
        if (caret_seen) begin
            got_sum = sum_bad ? 8'h00 : sum_capture;
            if (got_sum != rx_xor) begin
                rx_clear();
                return;
            end
        end
        if (tokens == 4'd0 || (id_phase != SEQ_NONE && id_capture != seq_id)) begin
            rx_clear();
            return;
        end
        if (first_tok == MATCH_OK || first_tok == MATCH_OK_SP)      st = ST_OK;
        else if (first_tok == MATCH_NK || first_tok == MATCH_NK_SP) st = ST_REFUSED;
        else                                                        st = ST_INVALID;
        rx_clear();
        armed = 1'b0;
        push_beat(KIND_STATUS, 8'h00, st, 1'b1);
    endtask

    task automatic take_line_byte(input logic [7:0] c);
        int d;
        if (!armed) return;
        if (rx_len == 6'd0 && c != cfg_start) return;
        if (rx_len != 6'd0 && c == cfg_end) begin
            close_frame();
            return;
        end
        rx_len++;
        if (!caret_seen) begin
            if (c == CHAR_CARET) begin
                caret_seen = 1'b1;
            end else begin
                rx_xor ^= c;
                take_token_byte(c);
            end
        end else if (sum_digits < 2'd2) begin
            d = digit_value(c);
            sum_digits++;
            if (d < 0) sum_bad = 1'b1;
            else       sum_capture = {sum_capture[3:0], d[3:0]};
        end
        if (rx_len >= RX_LIMIT) begin
            rx_clear();
            armed = 1'b0;
            push_beat(KIND_STATUS, 8'h00, ST_OVERFLOW, 1'b1);
        end
    endtask

    task automatic take_tick();
        if (!armed) return;
        if (ticks != 16'hFFFF) ticks++;
        if (ticks >= cfg_timeout) begin
            rx_clear();
            armed = 1'b0;
            push_beat(KIND_STATUS, 8'h00, ST_TIMEOUT, 1'b1);
        end
    endtask

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (want !== got) begin
            fail_total++;
            if (fail_total <= PRINT_LIMIT)
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    task automatic check_beat();
        link_beat_t want;
        if (expected_beats.size() == 0) begin
            fail_total++;
            if (fail_total <= PRINT_LIMIT)
                $display("%0t: beat with nothing expected, expected none actual %0h/%04h/%0h",
                         $time, i_m_tuser, i_m_tdata, i_m_tlast);
            return;
        end
        want = expected_beats.pop_front();
        compare_field("kind", 16'(want.kind), 16'(i_m_tuser));
        compare_field("line_byte", 16'(want.line_byte), 16'(i_m_tdata[7:0]));
        compare_field("status", 16'(want.status), 16'(i_m_tdata[10:8]));
        compare_field("pad bits", 16'h0000, 16'(i_m_tdata[15:11]));
        compare_field("last", 16'(want.last), 16'(i_m_tlast));
    endtask

    // Check the leaving beat first: a beat accepted now cannot be caused by this edge's input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            link_reset();
        end else begin
            if (i_m_tvalid && i_m_tready) check_beat();
            if (i_cfg_we) apply_reg(i_cfg_index, i_cfg_wdata);
            if (i_s_tvalid && i_s_tready) begin
                case (i_s_tuser)
                    CMD_TX_BYTE: begin
                        tx_sum ^= i_s_tdata;
                        push_beat(KIND_BYTE, i_s_tdata, ST_OK, 1'b1);
                    end
                    CMD_TX_END:  close_command();
                    CMD_RX_BYTE: take_line_byte(i_s_tdata);
                    default:     take_tick();
                endcase
            end
        end
        pending_total = expected_beats.size();
    end

endmodule

[test/tb_top.sv]
// Top of the command link testbench: clock, reset, register setup and beat stimulus.
// Depends on aclcs_pkg, the core under test and aclcs_link_checker for prediction.
`timescale 1ns / 1ps

module tb_top;
    import aclcs_pkg::*;

    localparam int PHASE_ITEMS = 16;
    localparam int NUM_PHASES  = 6;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_OFF    = 4;
    localparam int END_WAIT    = 16;

    typedef enum int {TOK_OK, TOK_NK, TOK_LONG, TOK_SHORT, TOK_RANDOM} first_token_e;
    typedef enum int {ID_NONE, ID_GOOD, ID_WRONG, ID_ONE, ID_BAD} id_mode_e;
    typedef enum int {
        SUM_GOOD, SUM_WRONG, SUM_BADDIG, SUM_ONE, SUM_NONE, SUM_MISSING, SUM_EXTRA
    } sum_mode_e;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_valid   = 1'b0;
    logic [7:0]  s_data    = 8'h00;
    logic [1:0]  s_user    = CMD_TICK;
    logic        m_ready   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_index = CFG_TIMEOUT;
    logic [15:0] cfg_wdata = 16'h0000;
    logic        s_ready, m_valid, m_user, m_last;
    logic [15:0] m_data;
    int          fail_count, pending;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int items_sent    = 0;
    int stall_cycles  = 0;

    // Shadow of the written registers, used to build well-formed replies
    logic [15:0] tb_timeout = 16'd1000;
    logic        tb_seq_en  = 1'b0;
    logic [7:0]  tb_seed = 8'd1, tb_start = 8'd36, tb_end = 8'd13;
    logic [7:0]  tb_marker = 8'd58, tb_invalid = 8'd0, tb_seq_id = 8'd0;

    ascii_command_link_checksum_seq_core uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .o_m_axis_tlast  (m_last),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata)
    );

    aclcs_link_checker checker_inst (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_valid),
        .i_s_tready   (s_ready),
        .i_s_tdata    (s_data),
        .i_s_tuser    (s_user),
        .i_m_tvalid   (m_valid),
        .i_m_tready   (m_ready),
        .i_m_tdata    (m_data),
        .i_m_tuser    (m_user),
        .i_m_tlast    (m_last),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    // Stall the output side at random
    always @(negedge clk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // End the run when nothing moves for too long
    always @(posedge clk) begin
        if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    function automatic logic [7:0] hex_ascii(input logic [3:0] d);
        return (d < 4'd10) ? 8'h30 + 8'(d) : 8'h41 + 8'(d) - 8'd10;
    endfunction

    // Offer one beat, idling first at random, and hold it until accepted
    task automatic send_item(input logic [1:0] cmd, input logic [7:0] b);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge clk);
        end
        s_valid <= 1'b1;
        s_user  <= cmd;
        s_data  <= b;
        do @(posedge clk); while (!s_ready);
        items_sent++;
    endtask

    task automatic send_command_end();
        send_item(CMD_TX_END, 8'($urandom_range(0, 255)));
        if (tb_seq_en) begin
            tb_seq_id++;
            if (tb_seq_id == tb_invalid) tb_seq_id++;
        end
    endtask

    // Drop valid and wait until every expected beat has left, plus a short hold-off
    task automatic settle();
        @(negedge clk);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (HOLD_OFF) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [15:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_TIMEOUT:  tb_timeout = value;
            CFG_SEQ_EN: begin
                tb_seq_en = value[0];
                tb_seq_id = value[0] ? tb_seed : tb_invalid;
            end
            CFG_SEQ_SEED: tb_seed    = value[7:0];
            CFG_START:    tb_start   = value[7:0];
            CFG_END:      tb_end     = value[7:0];
            CFG_SEQ_CHAR: tb_marker  = value[7:0];
            CFG_INVALID:  tb_invalid = value[7:0];
            default: ;
        endcase
    endtask

    // Load one register setting; the enable goes last so it loads the new seed
    task automatic apply_setting(input int p);
        logic [15:0] tmo;
        logic [7:0]  seed, start_c, end_c, marker, inval;
        logic        en;
        case (p)
            1: begin
                tmo = 16'hFFFF; seed = 8'hFF; start_c = 8'h23; end_c = 8'h0D;
                marker = 8'h3A; inval = 8'h00; en = 1'b1;
            end
            2: begin
                tmo = 16'h0000; seed = 8'h10; start_c = CHAR_CARET; end_c = 8'hFF;
                marker = 8'h40; inval = 8'h11; en = 1'b1;
            end
            3: begin
                tmo = 16'd5; seed = 8'hFE; start_c = 8'h00; end_c = 8'h0A;
                marker = 8'hFF; inval = 8'hFF; en = 1'b0;
            end
            4: begin
                tmo = 16'd20; seed = 8'h7F; start_c = 8'h24; end_c = 8'h0D;
                marker = 8'h3A; inval = 8'h80; en = 1'b1;
            end
            default: begin
                tmo = 16'd300; seed = 8'hA5; start_c = 8'hFF; end_c = 8'h00;
                marker = 8'h7E; inval = 8'hA6; en = 1'b1;
            end
        endcase
        cfg_write(CFG_TIMEOUT, tmo);
        cfg_write(CFG_SEQ_SEED, 16'(seed));
        cfg_write(CFG_START, 16'(start_c));
        cfg_write(CFG_END, 16'(end_c));
        cfg_write(CFG_SEQ_CHAR, 16'(marker));
        cfg_write(CFG_INVALID, 16'(inval));
        cfg_write(CFG_SEQ_EN, 16'(en));
    endtask

    // Build a reply frame for the current settings and send it, with stray ticks
    task automatic send_reply(input first_token_e tok, input id_mode_e idm,
                              input sum_mode_e sm);
        logic [7:0] frame[$];
        logic [7:0] acc, wrong;
        int         n, i;
        frame.push_back(tb_start);
        case (tok)
            TOK_OK: begin
                frame.push_back(CHAR_O);
                frame.push_back(CHAR_K);
            end
            TOK_NK: begin
                frame.push_back(CHAR_N);
                frame.push_back(CHAR_K);
            end
            TOK_LONG: begin
                frame.push_back($urandom_range(0, 1) ? CHAR_O : CHAR_N);
                frame.push_back(CHAR_K);
                frame.push_back(8'($urandom_range(0, 255)));
            end
            TOK_SHORT: frame.push_back($urandom_range(0, 1) ? CHAR_O : CHAR_N);
            default: begin
                n = $urandom_range(0, 3);
                repeat (n) frame.push_back(8'($urandom_range(0, 255)));
            end
        endcase
        // Extra tokens, sometimes past the token limit
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 11) : $urandom_range(0, 2);
        repeat (n) begin
            frame.push_back(CHAR_SPACE);
            frame.push_back(8'h41 + 8'($urandom_range(0, 25)));
        end
        if (idm != ID_NONE) begin
            frame.push_back(CHAR_SPACE);
            frame.push_back(tb_marker);
        end
        case (idm)
            ID_GOOD: begin
                frame.push_back(hex_ascii(tb_seq_id[7:4]));
                frame.push_back(hex_ascii(tb_seq_id[3:0]));
            end
            ID_WRONG: begin
                wrong = tb_seq_id ^ 8'($urandom_range(1, 255));
                frame.push_back(hex_ascii(wrong[7:4]));
                frame.push_back(hex_ascii(wrong[3:0]));
            end
            ID_ONE: frame.push_back(hex_ascii(tb_seq_id[3:0]));
            ID_BAD: begin
                frame.push_back(8'h47);
                frame.push_back(hex_ascii(tb_seq_id[3:0]));
            end
            default: ;
        endcase
        acc = 8'h00;
        foreach (frame[i]) acc ^= frame[i];
        if (sm == SUM_WRONG) acc ^= 8'($urandom_range(1, 255));
        if (sm != SUM_MISSING) frame.push_back(CHAR_CARET);
        case (sm)
            SUM_GOOD, SUM_WRONG, SUM_EXTRA: begin
                frame.push_back(hex_ascii(acc[7:4]));
                frame.push_back(hex_ascii(acc[3:0]));
                if (sm == SUM_EXTRA) frame.push_back(hex_ascii(4'($urandom_range(0, 15))));
            end
            SUM_BADDIG: begin
                frame.push_back(8'h67);
                frame.push_back(hex_ascii(acc[3:0]));
            end
            SUM_ONE: frame.push_back(hex_ascii(acc[3:0]));
            default: ;
        endcase
        frame.push_back(tb_end);
        for (i = 0; i < frame.size(); i++) begin
            if ($urandom_range(0, 19) == 0) send_item(CMD_TICK, 8'($urandom_range(0, 255)));
            send_item(CMD_RX_BYTE, frame[i]);
        end
    endtask

    // Start byte followed by enough bytes to fill the receive buffer
    task automatic send_overflow();
        logic [7:0] b;
        send_item(CMD_RX_BYTE, tb_start);
        repeat (RX_LIMIT + 1) begin
            b = 8'($urandom_range(0, 255));
            if (b == tb_end) b = ~b;
            send_item(CMD_RX_BYTE, b);
        end
    endtask

    // One command with a random reply, a timeout, an overflow, no reply or plain noise
    task automatic run_transaction(input logic force_overflow);
        int        pick, n, r;
        id_mode_e  idm;
        sum_mode_e sm;
        pick = $urandom_range(0, 15);
        if (pick == 0 && !force_overflow) begin
            n = $urandom_range(1, 3);
            repeat (n) send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            return;
        end
        n = $urandom_range(0, 4);
        repeat (n) send_item(CMD_TX_BYTE, 8'($urandom_range(0, 255)));
        send_command_end();
        if (force_overflow || pick == 2) begin
            send_overflow();
            return;
        end
        if (pick == 1) begin
            n = (tb_timeout <= 16'd30) ? int'(tb_timeout) + 1 : 3;
            repeat (n) send_item(CMD_TICK, 8'($urandom_range(0, 255)));
            return;
        end
        if (pick == 3) return;
        r = $urandom_range(0, 9);
        if (!tb_seq_en && $urandom_range(0, 1)) idm = ID_NONE;
        else if (r < 6) idm = ID_GOOD;
        else idm = id_mode_e'(r - 5);
        r = $urandom_range(0, 11);
        sm = (r < 5 || r == 11) ? SUM_GOOD : sum_mode_e'(r - 4);
        if ($urandom_range(0, 3) == 0) send_item(CMD_RX_BYTE, 8'($urandom_range(0, 255)));
        send_reply(first_token_e'($urandom_range(0, 4)), idm, sm);
    endtask

    initial begin
        int p, phase_start;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 18;
        recv_idle_pct = 57;

        // Directed: ignored beats while disarmed, byte extremes, ok, refused, bad digit
        send_item(CMD_TICK, 8'hFF);
        send_item(CMD_RX_BYTE, 8'h24);
        send_item(CMD_TX_BYTE, 8'h00);
        send_item(CMD_TX_BYTE, 8'hFF);
        send_command_end();
        send_reply(TOK_OK, ID_NONE, SUM_GOOD);
        send_command_end();
        send_reply(TOK_NK, ID_NONE, SUM_MISSING);
        send_command_end();
        send_reply(TOK_SHORT, ID_NONE, SUM_BADDIG);

        for (p = 0; p < NUM_PHASES; p++) begin
            if (p > 0) begin
                settle();
                apply_setting(p);
            end
            send_idle_pct = (p < 2) ? 18 : (p < 4) ? 57 : 0;
            recv_idle_pct = (p < 2) ? 57 : (p < 4) ? 18 : 0;
            phase_start = items_sent;
            run_transaction(p == 5);
            while (items_sent - phase_start < PHASE_ITEMS) run_transaction(1'b0);
        end

        settle();
        repeat (END_WAIT) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[files.f]
sv/aclcs_pkg.sv
sv/ascii_command_link_checksum_seq_core.sv
test/aclcs_link_checker.sv
test/tb_top.sv
